// ===== rtl/tlprd_pkg.sv =====
// Package with the types, codes and CRC function shared by the packet decoder.
package tlprd_pkg;

	localparam int unsigned POS_W = 13;
	localparam int unsigned CNT_W = POS_W + 1;
	localparam int unsigned HDR_BYTES = 12;
	localparam logic [POS_W-1:0] POS_MAX = '1;
	localparam logic [POS_W-1:0] HDR_END = POS_W'(HDR_BYTES);
	localparam logic [CNT_W-1:0] MIN_COUNT = CNT_W'(16);
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	localparam logic [4:0] TYPE_MEM = 5'h00;
	localparam logic [4:0] TYPE_CPL = 5'h0A;
	localparam logic [4:0] TYPE_CFG0 = 5'h05;
	localparam logic [4:0] TYPE_CFG1 = 5'h04;
	localparam logic [4:0] TYPE_MSG = 5'h12;
	localparam logic [4:0] TYPE_MSGD = 5'h1A;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_SHORT = 2'd1,
		ERR_HDR4  = 2'd2,
		ERR_LCRC  = 2'd3
	} err_t;

	typedef enum logic [3:0] {
		KIND_UNKNOWN = 4'd0,
		KIND_MRD     = 4'd1,
		KIND_MWR     = 4'd2,
		KIND_CPL     = 4'd3,
		KIND_CPLD    = 4'd4,
		KIND_CFGRD0  = 4'd5,
		KIND_CFGWR0  = 4'd6,
		KIND_CFGRD1  = 4'd7,
		KIND_CFGWR1  = 4'd8,
		KIND_MSG     = 4'd9,
		KIND_MSGD    = 4'd10
	} kind_t;

	typedef struct packed {
		logic        record_type;
		logic [7:0]  payload_byte;
		logic [1:0]  error_code;
		logic [3:0]  tlp_kind;
		logic [2:0]  traffic_class;
		logic [3:0]  header_flags;
		logic [9:0]  len_field;
		logic [15:0] req_id;
		logic [15:0] cpl_id;
		logic [7:0]  tag_value;
		logic [31:0] address;
		logic [13:0] completion_info;
	} rec_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== rtl/tlprd_in_if.sv =====
// Channel interface for packet bytes entering the decoder.
interface tlprd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       is_last;

	modport source(output valid, output byte_value, output is_last, input ready);
	modport sink(input valid, input byte_value, input is_last, output ready);
endinterface

// ===== rtl/tlprd_out_if.sv =====
// Channel interface for payload and summary records leaving the decoder.
interface tlprd_out_if;
	logic        valid;
	logic        ready;
	logic        record_type;
	logic [7:0]  payload_byte;
	logic [1:0]  error_code;
	logic [3:0]  tlp_kind;
	logic [2:0]  traffic_class;
	logic [3:0]  header_flags;
	logic [9:0]  len_field;
	logic [15:0] req_id;
	logic [15:0] cpl_id;
	logic [7:0]  tag_value;
	logic [31:0] address;
	logic [13:0] completion_info;

	modport source(output valid, output record_type, output payload_byte, output error_code,
		output tlp_kind, output traffic_class, output header_flags, output len_field,
		output req_id, output cpl_id, output tag_value, output address,
		output completion_info, input ready);
	modport sink(input valid, input record_type, input payload_byte, input error_code,
		input tlp_kind, input traffic_class, input header_flags, input len_field,
		input req_id, input cpl_id, input tag_value, input address,
		input completion_info, output ready);
endinterface

// ===== rtl/tlprd_parse.sv =====
// Byte parser: header capture, CRC-32 accumulation, LCRC capture and record formation.
module tlprd_parse (
	input  logic              clk,
	input  logic              arst_n,
	tlprd_in_if.sink          byte_ch,
	input  logic              buf_ready,
	output logic              push,
	output tlprd_pkg::rec_t   rec
);
	import tlprd_pkg::*;

	logic [POS_W-1:0] pos_q, pos_n;
	logic [7:0]       hdr_q [HDR_BYTES];
	logic [31:0]      crc_q, crc_n;
	logic [31:0]      crc_trl_q, crc_trl_n;
	logic [31:0]      lcrc_q, lcrc_n;
	logic [POS_W-1:0] trl_q, trl_n;

	logic             acc;
	logic             last;
	logic [7:0]       b;
	logic             in_hdr, in_pay, in_trl, fwd;
	logic [CNT_W-1:0] count;
	logic [CNT_W-1:0] trl_end;
	logic [1:0]       trl_idx;
	logic [9:0]       len;
	logic [10:0]      len_eff;
	logic [POS_W-1:0] pay;
	logic [2:0]       fmt;
	logic [4:0]       typ;
	err_t             err;
	rec_t             sum;

	assign byte_ch.ready = buf_ready;
	assign acc = byte_ch.valid && buf_ready;
	assign last = byte_ch.is_last;
	assign b = byte_ch.byte_value;

	assign trl_end = {1'b0, trl_q} + CNT_W'(4);
	assign in_hdr = pos_q < HDR_END;
	assign in_pay = !in_hdr && (pos_q < trl_q);
	assign in_trl = !in_hdr && !in_pay && ({1'b0, pos_q} < trl_end);
	assign trl_idx = 2'(pos_q - trl_q);
	assign count = {1'b0, pos_q} + CNT_W'(1);
	assign fmt = hdr_q[3][7:5];
	assign typ = hdr_q[3][4:0];
	assign fwd = in_pay && !hdr_q[3][7];

	assign len = {hdr_q[1][1:0], hdr_q[0]};
	assign len_eff = (len == 10'd0) ? 11'd1024 : {1'b0, len};
	assign pay = b[6] ? {len_eff, 2'b00} : '0;

	always_comb begin
		crc_n = crc_q;
		crc_trl_n = crc_trl_q;
		lcrc_n = lcrc_q;
		trl_n = trl_q;
		if (in_hdr || in_pay) begin
			crc_n = crc_byte(crc_q, b);
		end
		if (in_hdr && pos_q == POS_W'(3)) begin
			trl_n = HDR_END + pay;
		end
		if (in_trl) begin
			if (pos_q == trl_q) begin
				crc_trl_n = ~crc_q;
			end
			lcrc_n = lcrc_q | ({24'd0, b} << {trl_idx, 3'b000});
		end
		pos_n = (pos_q == POS_MAX) ? pos_q : pos_q + POS_W'(1);
	end

	always_comb begin
		sum = '0;
		sum.record_type = 1'b1;
		if (count < MIN_COUNT) begin
			err = ERR_SHORT;
		end else if (fmt[2]) begin
			err = ERR_HDR4;
		end else if (count < trl_end) begin
			err = ERR_SHORT;
		end else if (lcrc_n != crc_trl_n) begin
			err = ERR_LCRC;
		end else begin
			err = ERR_OK;
		end
		sum.error_code = err;
		if (err == ERR_OK || err == ERR_LCRC) begin
			sum.traffic_class = hdr_q[2][6:4];
			sum.header_flags = {hdr_q[1][7], hdr_q[1][6], hdr_q[1][5:4]};
			sum.len_field = len;
			case (typ)
				TYPE_MEM: begin
					sum.tlp_kind = fmt[1] ? KIND_MWR : KIND_MRD;
					sum.req_id = {hdr_q[5], hdr_q[4]};
					sum.tag_value = hdr_q[6];
					sum.address = {hdr_q[11], hdr_q[10], hdr_q[9], hdr_q[8]};
				end
				TYPE_CPL: begin
					sum.tlp_kind = fmt[1] ? KIND_CPLD : KIND_CPL;
					sum.cpl_id = {hdr_q[5], hdr_q[4]};
					sum.completion_info = {hdr_q[6][5:3], hdr_q[6][2:0], hdr_q[7]};
					sum.tag_value = hdr_q[9];
					sum.req_id = {hdr_q[10], hdr_q[11]};
				end
				TYPE_CFG0: begin
					sum.tlp_kind = fmt[1] ? KIND_CFGWR0 : KIND_CFGRD0;
					sum.req_id = {hdr_q[5], hdr_q[4]};
					sum.tag_value = hdr_q[6];
				end
				TYPE_CFG1: begin
					sum.tlp_kind = fmt[1] ? KIND_CFGWR1 : KIND_CFGRD1;
					sum.req_id = {hdr_q[5], hdr_q[4]};
					sum.tag_value = hdr_q[6];
				end
				TYPE_MSG: begin
					sum.tlp_kind = KIND_MSG;
					sum.req_id = {hdr_q[5], hdr_q[4]};
					sum.tag_value = hdr_q[6];
				end
				TYPE_MSGD: begin
					sum.tlp_kind = KIND_MSGD;
					sum.req_id = {hdr_q[5], hdr_q[4]};
					sum.tag_value = hdr_q[6];
				end
				default: begin
					sum.tlp_kind = KIND_UNKNOWN;
				end
			endcase
		end
	end

	always_comb begin
		rec = '0;
		if (last) begin
			rec = sum;
		end else begin
			rec.payload_byte = b;
		end
	end

	assign push = acc && (last || fwd);

	always_ff @(posedge clk) begin
		if (acc && in_hdr) begin
			hdr_q[pos_q[3:0]] <= b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= CRC_INIT;
			crc_trl_q <= '0;
			lcrc_q <= '0;
			trl_q <= HDR_END;
		end else if (acc) begin
			if (last) begin
				pos_q <= '0;
				crc_q <= CRC_INIT;
				crc_trl_q <= '0;
				lcrc_q <= '0;
				trl_q <= HDR_END;
			end else begin
				pos_q <= pos_n;
				crc_q <= crc_n;
				crc_trl_q <= crc_trl_n;
				lcrc_q <= lcrc_n;
				trl_q <= trl_n;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		acc && last |=> pos_q == '0 && crc_q == CRC_INIT && lcrc_q == '0 && trl_q == HDR_END)
		else $error("Packet state not cleared after the final byte.");

	a_pos_advance: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !last && pos_q != POS_MAX |=> pos_q == $past(pos_q) + POS_W'(1))
		else $error("Byte position did not advance on a transfer.");

	a_trailer_floor: assert property (@(posedge clk) disable iff (!arst_n)
		trl_q >= HDR_END)
		else $error("Trailer offset fell below the header size.");

	a_no_fwd_hdr4: assert property (@(posedge clk) disable iff (!arst_n)
		push && !last |-> !hdr_q[3][7] && !in_hdr)
		else $error("Payload record from a header byte or a four-dword packet.");
`endif
endmodule

// ===== rtl/tlprd_outbuf.sv =====
// Two-entry output buffer: result register plus skid register on the record channel.
module tlprd_outbuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tlprd_pkg::rec_t   rec,
	output logic              buf_ready,
	tlprd_out_if.source       rec_ch
);
	import tlprd_pkg::*;

	rec_t head_q, skid_q;
	logic head_vld_q, skid_vld_q;
	logic pop;

	assign pop = head_vld_q && rec_ch.ready;
	assign buf_ready = !skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (pop) begin
				skid_vld_q <= 1'b0;
			end
		end else if (!head_vld_q || pop) begin
			head_vld_q <= push;
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (pop) begin
				head_q <= skid_q;
			end
		end else if (!head_vld_q || pop) begin
			head_q <= rec;
		end else if (push) begin
			skid_q <= rec;
		end
	end

	assign rec_ch.valid = head_vld_q;
	assign rec_ch.record_type = head_q.record_type;
	assign rec_ch.payload_byte = head_q.payload_byte;
	assign rec_ch.error_code = head_q.error_code;
	assign rec_ch.tlp_kind = head_q.tlp_kind;
	assign rec_ch.traffic_class = head_q.traffic_class;
	assign rec_ch.header_flags = head_q.header_flags;
	assign rec_ch.len_field = head_q.len_field;
	assign rec_ch.req_id = head_q.req_id;
	assign rec_ch.cpl_id = head_q.cpl_id;
	assign rec_ch.tag_value = head_q.tag_value;
	assign rec_ch.address = head_q.address;
	assign rec_ch.completion_info = head_q.completion_info;
endmodule

// ===== rtl/tlp_receive_decoder_core.sv =====
// Top level of the receive decoder for packets with a three-dword header.
//
// Channel   Role  Payload
// byte_ch   sink  byte_value, is_last
// rec_ch    src   record_type, payload_byte and the summary header fields
//
// One byte is taken per cycle while the skid register is empty; its record is registered.
// The CRC-32 byte update and the LCRC compare sit between the byte and the result register.
// A skid register lets one more byte be taken while the output is stalled.
// Reset clears the position, CRC and trailer state; the header bytes need no reset.
module tlp_receive_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	tlprd_in_if.sink    byte_ch,
	tlprd_out_if.source rec_ch
);
	import tlprd_pkg::*;

	logic buf_ready;
	logic push;
	rec_t rec;

	tlprd_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.buf_ready (buf_ready),
		.push      (push),
		.rec       (rec)
	);

	tlprd_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.rec       (rec),
		.buf_ready (buf_ready),
		.rec_ch    (rec_ch)
	);
endmodule

// ===== tb/tlprd_check_pkg.sv =====
// Scoreboard class that predicts and checks decoder records for the packet decoder testbench.
package tlprd_check_pkg;

	import tlprd_pkg::*;

	class tlp_record_checker;
		bit [12:0] position;
		bit [7:0]  header[12];
		bit [31:0] crc_run;
		bit [31:0] crc_frozen;
		bit [31:0] lcrc_seen;
		int        trailer_at;
		rec_t      expected_records[$];
		int        errors;
		int        payload_seen;
		int        summary_seen[4];

		function new();
			errors = 0;
			payload_seen = 0;
			foreach (summary_seen[i]) summary_seen[i] = 0;
			restart();
		endfunction

		function void restart();
			position = '0;
			crc_run = '1;
			crc_frozen = '0;
			lcrc_seen = '0;
			trailer_at = 12;
		endfunction

		static function bit [31:0] crc_update(bit [31:0] c, bit [7:0] b);
			bit fb;
			for (int i = 0; i < 8; i++) begin
				fb = c[0] ^ b[i];
				c = c >> 1;
				if (fb) c = c ^ 32'hEDB8_8320;
			end
			return c;
		endfunction

		function rec_t summarize(int count);
			rec_t       r;
			bit [2:0]   fmt;
			bit [4:0]   typ;
			bit         data;
			bit [15:0]  dw1lo;
			r = '0;
			r.record_type = 1'b1;
			fmt = header[3][7:5];
			typ = header[3][4:0];
			data = fmt[1];
			dw1lo = {header[5], header[4]};
			if (count < 16) r.error_code = ERR_SHORT;
			else if (fmt[2]) r.error_code = ERR_HDR4;
			else if (count < trailer_at + 4) r.error_code = ERR_SHORT;
			else if (lcrc_seen != crc_frozen) r.error_code = ERR_LCRC;
			else r.error_code = ERR_OK;
			if (r.error_code == ERR_SHORT || r.error_code == ERR_HDR4) return r;
			case (typ)
				TYPE_MEM: begin
					r.tlp_kind = data ? KIND_MWR : KIND_MRD;
					r.req_id = dw1lo;
					r.tag_value = header[6];
					r.address = {header[11], header[10], header[9], header[8]};
				end
				TYPE_CPL: begin
					r.tlp_kind = data ? KIND_CPLD : KIND_CPL;
					r.cpl_id = dw1lo;
					r.completion_info = {header[6][5:3], header[6][2:0], header[7]};
					r.tag_value = header[9];
					r.req_id = {header[10], header[11]};
				end
				TYPE_CFG0: begin
					r.tlp_kind = data ? KIND_CFGWR0 : KIND_CFGRD0;
					r.req_id = dw1lo;
					r.tag_value = header[6];
				end
				TYPE_CFG1: begin
					r.tlp_kind = data ? KIND_CFGWR1 : KIND_CFGRD1;
					r.req_id = dw1lo;
					r.tag_value = header[6];
				end
				TYPE_MSG, TYPE_MSGD: begin
					r.tlp_kind = (typ == TYPE_MSG) ? KIND_MSG : KIND_MSGD;
					r.req_id = dw1lo;
					r.tag_value = header[6];
				end
				default: ;
			endcase
			r.traffic_class = header[2][6:4];
			r.header_flags = {header[1][7], header[1][6], header[1][5:4]};
			r.len_field = {header[1][1:0], header[0]};
			return r;
		endfunction

		function void take_byte(bit [7:0] b, bit last);
			int       p;
			bit       fwd;
			int       len;
			int       pay;
			rec_t     r;
			p = position;
			fwd = 1'b0;
			if (p < 12) begin
				header[p] = b;
				crc_run = crc_update(crc_run, b);
				if (p == 3) begin
					len = {header[1][1:0], header[0]};
					pay = 0;
					if (b[6]) pay = ((len == 0) ? 1024 : len) * 4;
					trailer_at = 12 + pay;
				end
			end else if (p < trailer_at) begin
				crc_run = crc_update(crc_run, b);
				fwd = !header[3][7];
			end else if (p < trailer_at + 4) begin
				if (p == trailer_at) crc_frozen = ~crc_run;
				lcrc_seen = lcrc_seen | (32'(b) << (8 * (p - trailer_at)));
			end
			if (position != 13'h1FFF) position = position + 1'b1;
			if (last) begin
				expected_records.insert(expected_records.size(), summarize(p + 1));
				restart();
			end else if (fwd) begin
				r = '0;
				r.payload_byte = b;
				expected_records.insert(expected_records.size(), r);
			end
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= 50) $display("MISMATCH: %s", msg);
		endfunction

		function void check_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("%s got %0h, expected %0h", name, got, want));
		endfunction

		function void check_record(rec_t got);
			rec_t want;
			if (expected_records.size() == 0) begin
				report("record arrived with nothing expected");
				return;
			end
			want = expected_records.pop_front();
			check_field("record_type", got.record_type, want.record_type);
			check_field("payload_byte", got.payload_byte, want.payload_byte);
			check_field("error_code", got.error_code, want.error_code);
			check_field("tlp_kind", got.tlp_kind, want.tlp_kind);
			check_field("traffic_class", got.traffic_class, want.traffic_class);
			check_field("header_flags", got.header_flags, want.header_flags);
			check_field("len_field", got.len_field, want.len_field);
			check_field("req_id", got.req_id, want.req_id);
			check_field("cpl_id", got.cpl_id, want.cpl_id);
			check_field("tag_value", got.tag_value, want.tag_value);
			check_field("address", got.address, want.address);
			check_field("completion_info", got.completion_info, want.completion_info);
			if (want.record_type) summary_seen[want.error_code]++;
			else payload_seen++;
		endfunction
	endclass

endpackage

// ===== tb/tlp_receive_decoder_core_test.sv =====
// Top module of the testbench that feeds packets to the decoder and checks its records.
module tlp_receive_decoder_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tlprd_pkg::*;
	import tlprd_check_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam logic [2:0] FMT_NODATA = 3'b000;
	localparam logic [2:0] FMT_DATA = 3'b010;
	localparam logic [2:0] FMT_HDR4 = 3'b100;
	localparam logic [4:0] TYPE_ODD = 5'h1F;

	logic clk = 1'b0;
	logic arst_n;
	int   cycles = 0;
	int   bytes_sent = 0;
	int   packets = 0;

	tlprd_in_if  byte_ch();
	tlprd_out_if rec_ch();

	tlp_record_checker sb = new();

	tlp_receive_decoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_ch(byte_ch),
		.rec_ch(rec_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles.", cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin : watch
		rec_t got;
		if (arst_n && rec_ch.valid && rec_ch.ready) begin
			got = {rec_ch.record_type, rec_ch.payload_byte, rec_ch.error_code, rec_ch.tlp_kind,
				rec_ch.traffic_class, rec_ch.header_flags, rec_ch.len_field,
				rec_ch.req_id, rec_ch.cpl_id, rec_ch.tag_value, rec_ch.address,
				rec_ch.completion_info};
			sb.check_record(got);
		end
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	initial begin : sink_side
		int stall_left;
		int mode_left;
		bit quiet;
		stall_left = 0;
		mode_left = 0;
		quiet = 1'b0;
		rec_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				quiet = ($urandom_range(0, 3) == 0);
				mode_left = $urandom_range(50, 300);
			end
			mode_left--;
			if (stall_left > 0) begin
				rec_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rec_ch.ready <= 1'b1;
				if (!quiet && $urandom_range(0, 3) == 0) stall_left = idle_len();
			end
		end
	end

	function automatic logic [4:0] pick_type();
		logic [4:0] known[6];
		known = '{TYPE_MEM, TYPE_CPL, TYPE_CFG0, TYPE_CFG1, TYPE_MSG, TYPE_MSGD};
		if ($urandom_range(0, 99) < 85) return known[$urandom_range(0, 5)];
		return 5'($urandom);
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic last, input bit quiet);
		int gap;
		gap = (!quiet && $urandom_range(0, 3) == 0) ? idle_len() : 0;
		@(negedge clk);
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.byte_value <= b;
		byte_ch.is_last <= last;
		@(posedge clk);
		while (!byte_ch.ready) @(posedge clk);
		sb.take_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_packet(input logic [2:0] fmt, input logic [4:0] typ,
		input logic [9:0] len, input bit bad_crc, input int extra, input int cut);
		logic [7:0]  pkt[$];
		logic [31:0] crc;
		int          pay;
		int          n;
		bit          quiet;
		quiet = ($urandom_range(0, 4) == 0);
		for (int k = 0; k < 12; k++) pkt.insert(pkt.size(), 8'($urandom));
		pkt[0] = len[7:0];
		pkt[1] = {pkt[1][7:2], len[9:8]};
		pkt[3] = {fmt, typ};
		pay = fmt[1] ? ((len == 0) ? 1024 : int'(len)) * 4 : 0;
		repeat (pay) pkt.insert(pkt.size(), 8'($urandom));
		crc = '1;
		foreach (pkt[i]) crc = tlp_record_checker::crc_update(crc, pkt[i]);
		crc = ~crc;
		if (bad_crc) crc = crc ^ (32'd1 << $urandom_range(0, 31));
		for (int k = 0; k < 4; k++) pkt.insert(pkt.size(), crc[8*k +: 8]);
		repeat (extra) pkt.insert(pkt.size(), 8'($urandom));
		n = (cut >= 0 && cut < pkt.size()) ? cut + 1 : pkt.size();
		for (int k = 0; k < n; k++) push_byte(pkt[k], k == n - 1, quiet);
		packets++;
	endtask

	initial begin : source_side
		int          stop_at;
		int          r;
		int          n;
		logic [2:0]  fmt;
		logic [9:0]  len;
		byte_ch.valid = 1'b0;
		byte_ch.byte_value = '0;
		byte_ch.is_last = 1'b0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_packet(FMT_NODATA, TYPE_MEM, 10'd1, 1'b0, 0, -1);
		send_packet(FMT_DATA, TYPE_MEM, 10'd1, 1'b0, 0, -1);
		send_packet(FMT_NODATA, TYPE_CPL, 10'd3, 1'b0, 0, -1);
		send_packet(FMT_DATA, TYPE_CPL, 10'd2, 1'b0, 0, -1);
		send_packet(FMT_NODATA, TYPE_CFG0, 10'd1, 1'b0, 0, -1);
		send_packet(FMT_DATA, TYPE_CFG0, 10'd1, 1'b0, 0, -1);
		send_packet(FMT_NODATA, TYPE_CFG1, 10'd1, 1'b0, 0, -1);
		send_packet(FMT_DATA, TYPE_CFG1, 10'd1, 1'b0, 0, -1);
		send_packet(FMT_NODATA, TYPE_MSG, 10'h3FF, 1'b0, 0, -1);
		send_packet(FMT_DATA, TYPE_MSGD, 10'd1, 1'b0, 0, -1);
		send_packet(FMT_NODATA, TYPE_ODD, 10'd0, 1'b0, 0, -1);
		send_packet(FMT_HDR4, TYPE_MEM, 10'd1, 1'b0, 0, -1);
		send_packet(FMT_HDR4 | FMT_DATA, TYPE_MEM, 10'd2, 1'b0, 0, -1);
		send_packet(FMT_HDR4, TYPE_MEM, 10'd1, 1'b0, 0, 9);
		send_packet(FMT_NODATA, TYPE_MEM, 10'd1, 1'b0, 0, 14);
		send_packet(FMT_NODATA, TYPE_MEM, 10'd1, 1'b0, 0, 0);
		send_packet(FMT_DATA, TYPE_MEM, 10'd4, 1'b0, 0, 20);
		send_packet(FMT_DATA, TYPE_MEM, 10'd2, 1'b0, 0, 22);
		send_packet(FMT_DATA, TYPE_CPL, 10'd2, 1'b1, 0, -1);
		send_packet(FMT_NODATA, TYPE_CFG0, 10'd1, 1'b0, 5, -1);
		// Largest payload size, cut off long before its trailer.
		send_packet(FMT_DATA, TYPE_MEM, 10'd0, 1'b0, 0, 40);

		stop_at = bytes_sent + 1050;
		while (bytes_sent < stop_at) begin
			r = $urandom_range(0, 99);
			fmt = {1'b0, 1'($urandom), 1'($urandom)};
			len = fmt[1] ? 10'($urandom_range(1, 10)) : 10'($urandom);
			if (r < 72) begin
				send_packet(fmt, pick_type(), len, $urandom_range(0, 9) == 0,
					($urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : 0, -1);
			end else if (r < 82) begin
				fmt[2] = 1'b1;
				send_packet(fmt, pick_type(), len, 1'b0,
					($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0, -1);
			end else if (r < 92) begin
				n = 12 + (fmt[1] ? int'(len) * 4 : 0) + 3;
				send_packet(fmt, pick_type(), len, 1'b0, 0, $urandom_range(0, n));
			end else begin
				n = $urandom_range(1, 30);
				for (int k = 0; k < n; k++) push_byte(8'($urandom), k == n - 1, 1'b0);
				packets++;
			end
		end
		@(negedge clk);
		byte_ch.valid <= 1'b0;

		while (sb.expected_records.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);

		$display("Sent %0d packets (%0d bytes); checked %0d payload records.",
			packets, bytes_sent, sb.payload_seen);
		$display("Summaries: ok %0d, too short %0d, four-dword %0d, LCRC mismatch %0d.",
			sb.summary_seen[ERR_OK], sb.summary_seen[ERR_SHORT], sb.summary_seen[ERR_HDR4],
			sb.summary_seen[ERR_LCRC]);
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
